// ===== rtl/eepwe_pkg.sv =====
// Shared constants, types and register codes of the edge event pulse width encoder.
`default_nettype none

package eepwe_pkg;

  localparam int NUM_SOURCES = 9;
  localparam int QUEUE_DEPTH = 32;

  localparam int EVT_W  = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int RANK_W = $clog2(NUM_SOURCES + 1);
  localparam int CW     = (QCNT_W > RANK_W) ? QCNT_W : RANK_W;
  localparam int PSUM_W = ((QPTR_W > CW) ? QPTR_W : CW) + 1;

  localparam int TICK_W    = 16;
  localparam int FILL_W    = 6;
  localparam int CNT_W     = 20;
  localparam int LEN_W     = CNT_W + 1;
  localparam int CFG_IDX_W = 3;

  localparam logic [LEN_W-1:0] CODE_MAX_TICKS = LEN_W'(1) << CNT_W;

  localparam logic [TICK_W-1:0] LEAD_RESET = TICK_W'(500);
  localparam logic [TICK_W-1:0] GAP_RESET  = TICK_W'(100);
  localparam logic [TICK_W-1:0] BASE_RESET = TICK_W'(100);
  localparam logic [TICK_W-1:0] STEP_RESET = TICK_W'(100);
  localparam logic [TICK_W-1:0] TAIL_RESET = TICK_W'(500);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEAD = 3'd0,
    REG_GAP  = 3'd1,
    REG_BASE = 3'd2,
    REG_STEP = 3'd3,
    REG_TAIL = 3'd4
  } reg_idx_e;

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_LEAD = 7'b0000010,
    PH_GAP1 = 7'b0000100,
    PH_CODE = 7'b0001000,
    PH_GAP2 = 7'b0010000,
    PH_TAIL = 7'b0100000,
    PH_GAP3 = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [TICK_W-1:0] lead;
    logic [TICK_W-1:0] gap;
    logic [TICK_W-1:0] base;
    logic [TICK_W-1:0] step;
    logic [TICK_W-1:0] tail;
  } cfg_t;

  typedef struct packed {
    logic [NUM_SOURCES-1:0]             rise;
    logic [NUM_SOURCES-1:0][RANK_W-1:0] rank;
    logic [RANK_W-1:0]                  num;
    logic [EVT_W-1:0]                   first_idx;
  } push_req_t;

  typedef struct packed {
    logic line_level;
    logic frame_busy;
  } line_t;

  typedef struct packed {
    logic              line_level;
    logic              frame_busy;
    logic              drop_flag;
    logic [FILL_W-1:0] queue_fill;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/eepwe_front.sv =====
// Front end: pin arming and ordering of this tick's event requests.
`default_nettype none

module eepwe_front
  import eepwe_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   tick_i,
  input  wire logic [NUM_SOURCES-1:0] pins_i,
  output push_req_t                   push_o
);

  logic [NUM_SOURCES-1:0] armed_q;
  push_req_t              req;

  always_comb begin
    req           = '0;
    req.rise      = pins_i & ~armed_q;
    for (int s = 0; s < NUM_SOURCES; s++) begin
      for (int j = 0; j < NUM_SOURCES; j++) begin
        if (j < s) begin
          req.rank[s] = req.rank[s] + RANK_W'(req.rise[j]);
        end
      end
      req.num = req.num + RANK_W'(req.rise[s]);
    end
    for (int s = NUM_SOURCES - 1; s >= 0; s--) begin
      if (req.rise[s]) begin
        req.first_idx = EVT_W'(s);
      end
    end
  end

  assign push_o = req;

  // A high pin is armed and a low pin is disarmed on every tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
    end else if (tick_i) begin
      armed_q <= pins_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/eepwe_queue.sv =====
// Event index queue between the front end and the frame sequencer.
`default_nettype none

module eepwe_queue
  import eepwe_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              tick_i,
  input  wire push_req_t         push_i,
  input  wire logic              pop_i,
  output logic                   avail_o,
  output logic [EVT_W-1:0]       head_evt_o,
  output logic                   drop_o,
  output logic [FILL_W-1:0]      fill_o
);

  logic [EVT_W-1:0]   mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  head_q, head_d;
  logic [QPTR_W-1:0]  tail_q, tail_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic [CW-1:0]      free_slots;
  logic [CW-1:0]      n_acc;
  logic [NUM_SOURCES-1:0] acc;
  logic [QPTR_W-1:0]  wptr [NUM_SOURCES];
  logic [PSUM_W-1:0]  psum [NUM_SOURCES];
  logic [PSUM_W-1:0]  tsum;
  logic               pop;

  always_comb begin
    free_slots = CW'(QCNT_W'(QUEUE_DEPTH) - count_q);
    drop_o     = CW'(push_i.num) > free_slots;
    n_acc      = drop_o ? free_slots : CW'(push_i.num);
    for (int s = 0; s < NUM_SOURCES; s++) begin
      acc[s]  = push_i.rise[s] && (CW'(push_i.rank[s]) < free_slots);
      psum[s] = PSUM_W'(tail_q) + PSUM_W'(push_i.rank[s]);
      if (psum[s] >= PSUM_W'(QUEUE_DEPTH)) begin
        psum[s] = psum[s] - PSUM_W'(QUEUE_DEPTH);
      end
      wptr[s] = psum[s][QPTR_W-1:0];
    end
    tsum = PSUM_W'(tail_q) + PSUM_W'(n_acc);
    if (tsum >= PSUM_W'(QUEUE_DEPTH)) begin
      tsum = tsum - PSUM_W'(QUEUE_DEPTH);
    end
    tail_d = tsum[QPTR_W-1:0];

    avail_o    = (count_q != '0) || (push_i.num != '0);
    head_evt_o = (count_q == '0) ? push_i.first_idx : mem_q[head_q];
    pop        = pop_i && avail_o;

    if (pop) begin
      head_d = (head_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QPTR_W'(1);
    end else begin
      head_d = head_q;
    end
    count_d = count_q + QCNT_W'(n_acc) - QCNT_W'(pop);
    fill_o  = FILL_W'(count_d);
  end

  always_ff @(posedge clk_i) begin
    if (tick_i) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        if (acc[s]) begin
          mem_q[wptr[s]] <= EVT_W'(s);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (tick_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/eepwe_back.sv =====
// Frame sequencer: pops event indexes and drives the pulse frame on the line.
`default_nettype none

module eepwe_back
  import eepwe_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              tick_i,
  input  wire cfg_t              cfg_i,
  input  wire logic              avail_i,
  input  wire logic [EVT_W-1:0]  head_evt_i,
  output logic                   pop_o,
  output line_t                  line_o
);

  localparam int SUM_W = EVT_W + TICK_W + 2;

  phase_e            phase_q, phase_d, cur_phase;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cur_cnt;
  logic [EVT_W-1:0]  event_q, event_d;
  logic [LEN_W-1:0]  code_len;
  logic [EVT_W:0]    ev_plus;
  logic [SUM_W-1:0]  code_sum;
  logic [LEN_W-1:0]  raw_len, len;
  logic              start, done;

  // The code pulse length follows the registered event and the current register values.
  always_comb begin
    ev_plus  = {1'b0, event_q} + (EVT_W + 1)'(1);
    code_sum = SUM_W'(cfg_i.base) + SUM_W'(ev_plus) * SUM_W'(cfg_i.step);
    code_len = (code_sum > SUM_W'(CODE_MAX_TICKS)) ? CODE_MAX_TICKS : LEN_W'(code_sum);
  end

  always_comb begin
    start     = (phase_q == PH_IDLE) && avail_i;
    pop_o     = tick_i && start;
    cur_phase = start ? PH_LEAD : phase_q;
    cur_cnt   = start ? '0 : cnt_q;
    event_d   = start ? head_evt_i : event_q;

    unique case (cur_phase)
      PH_LEAD: raw_len = LEN_W'(cfg_i.lead);
      PH_CODE: raw_len = code_len;
      PH_TAIL: raw_len = LEN_W'(cfg_i.tail);
      default: raw_len = LEN_W'(cfg_i.gap);
    endcase
    len  = (raw_len == '0) ? LEN_W'(1) : raw_len;
    done = (LEN_W'(cur_cnt) + LEN_W'(1)) >= len;

    line_o.frame_busy = (cur_phase != PH_IDLE);
    line_o.line_level = (cur_phase == PH_LEAD) || (cur_phase == PH_CODE) ||
                        (cur_phase == PH_TAIL);

    phase_d = cur_phase;
    cnt_d   = cur_cnt;
    if (cur_phase != PH_IDLE) begin
      if (done) begin
        cnt_d = '0;
        unique case (cur_phase)
          PH_LEAD: phase_d = PH_GAP1;
          PH_GAP1: phase_d = PH_CODE;
          PH_CODE: phase_d = PH_GAP2;
          PH_GAP2: phase_d = PH_TAIL;
          PH_TAIL: phase_d = PH_GAP3;
          default: phase_d = PH_IDLE;
        endcase
      end else begin
        cnt_d = cur_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      event_q <= '0;
    end else if (tick_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      event_q <= event_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/eepwe_outbuf.sv =====
// Two-entry result buffer that decouples the output stall from tick acceptance.
`default_nettype none

module eepwe_outbuf
  import eepwe_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t data_i,
  output logic         full_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      data_o
);

  result_t     buf_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        pop;

  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign data_o      = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/edge_event_pulse_width_encoder.sv =====
// Top level of the edge event pulse width encoder.
// One tick is accepted per clock cycle unless stalled; its result is buffered for output.
// Every tick is handled in the cycle it is accepted by the front end, queue and sequencer.
// A two-entry result buffer holds finished results, so ticks stall only when it is full.
// Reset clears arming, queue pointers, the sequencer and the buffer and loads the default
// register values; queue entries are not cleared and no clearing pass is needed.
`default_nettype none

module edge_event_pulse_width_encoder
  import eepwe_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [NUM_SOURCES-1:0] pin_levels_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        line_level_o,
  output logic                        frame_busy_o,
  output logic                        drop_flag_o,
  output logic [FILL_W-1:0]           queue_fill_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [TICK_W-1:0]      cfg_data_i
);

  cfg_t              cfg_q;
  push_req_t         push;
  line_t             line;
  result_t           res, res_out;
  logic              tick, full, pop, avail, drop;
  logic [EVT_W-1:0]  head_evt;
  logic [FILL_W-1:0] fill;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign tick        = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lead <= LEAD_RESET;
      cfg_q.gap  <= GAP_RESET;
      cfg_q.base <= BASE_RESET;
      cfg_q.step <= STEP_RESET;
      cfg_q.tail <= TAIL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_LEAD: cfg_q.lead <= cfg_data_i;
        REG_GAP:  cfg_q.gap  <= cfg_data_i;
        REG_BASE: cfg_q.base <= cfg_data_i;
        REG_STEP: cfg_q.step <= cfg_data_i;
        REG_TAIL: cfg_q.tail <= cfg_data_i;
        default: ;
      endcase
    end
  end

  eepwe_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick),
    .pins_i (pin_levels_i),
    .push_o (push)
  );

  eepwe_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick),
    .push_i     (push),
    .pop_i      (pop),
    .avail_o    (avail),
    .head_evt_o (head_evt),
    .drop_o     (drop),
    .fill_o     (fill)
  );

  eepwe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick),
    .cfg_i      (cfg_q),
    .avail_i    (avail),
    .head_evt_i (head_evt),
    .pop_o      (pop),
    .line_o     (line)
  );

  always_comb begin
    res.line_level = line.line_level;
    res.frame_busy = line.frame_busy;
    res.drop_flag  = drop;
    res.queue_fill = fill;
  end

  eepwe_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (tick),
    .data_i      (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (res_out)
  );

  assign line_level_o = res_out.line_level;
  assign frame_busy_o = res_out.frame_busy;
  assign drop_flag_o  = res_out.drop_flag;
  assign queue_fill_o = res_out.queue_fill;

endmodule

`default_nettype wire
